[sv/sbd_pkg.sv]
// Shared types and constants for the scan block deframer and run-length decoder.
// Used by the front, queue, back and top level modules; no dependencies.
package sbd_pkg;

  localparam logic [7:0] TYPE_END_DATA  = 8'h80;
  localparam logic [7:0] TYPE_END_FRAME = 8'h82;
  localparam logic [7:0] TYPE_JPEG      = 8'h64;
  localparam logic [7:0] TYPE_RLE       = 8'h42;
  localparam logic [7:0] TYPE_RAW       = 8'h40;

  localparam int FRAME_HDR_LEN = 10;
  localparam int DATA_HDR_LEN  = 12;

  localparam logic [3:0] FRAME_HDR_LAST = 4'(FRAME_HDR_LEN - 1);
  localparam logic [3:0] DATA_HDR_LAST  = 4'(DATA_HDR_LEN - 1);
  localparam logic [3:0] DATA_HDR_LEN_LO = 4'(DATA_HDR_LEN - 2);

  localparam logic [7:0] CTRL_REPEAT_MIN = 8'h80;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    EV_DATA = 2'd0,
    EV_EOD  = 2'd1,
    EV_EOF  = 2'd2,
    EV_ERR  = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    OPK_EOD,
    OPK_EOF,
    OPK_ERR,
    OPK_RAW,
    OPK_RLE
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic       last;
  } sbd_op_t;

endpackage

[sv/scan_block_deframe_rle_decode.sv]
// Channel   Ports                                                  Word
// input     in_valid, in_stall, in_byte                            one raw stream byte
// result    out_valid, out_stall, out_event_res, out_value,        one event or decoded run
//           out_repeat_count
// One byte per cycle sustained while in_stall is low. Each result is registered first in the
// op queue (front end parse and queue write at the accepting edge), then in the output
// register (back end decode), which a stalled output holds.
// Throughput is set by the two-entry op queue and the single output register.
// rst_n is synchronous and active low and clears header, payload and run state.
// in_stall rises only when the op queue is full; a stalled output holds its word.
// Top level: instantiates sbd_front, sbd_queue and sbd_back; depends on sbd_pkg.
module scan_block_deframe_rle_decode
  import sbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [7:0] out_value,
  output logic [7:0] out_repeat_count
);

  logic    accept;
  logic    push;
  logic    pop;
  logic    q_empty;
  logic    q_full;
  sbd_op_t push_op;
  sbd_op_t head_op;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  sbd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push),
    .op      (push_op)
  );

  sbd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  sbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (!q_empty),
    .head_op          (head_op),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_value        (out_value),
    .out_repeat_count (out_repeat_count)
  );

endmodule

[sv/sbd_front.sv]
// Front end: parses block headers, counts payload and classifies payload bytes and header outcomes into ops.
// Depends on sbd_pkg; feeds sbd_queue.
module sbd_front
  import sbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       push,
  output sbd_op_t    op
);

  logic        in_payload_r, in_payload_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] len;
  logic        gen;

  assign len = {in_byte, len_lo_r};

  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_idx_nxt    = hdr_idx_r;
    kind_nxt       = kind_r;
    len_lo_nxt     = len_lo_r;
    left_nxt       = left_r;
    gen            = 1'b0;
    op.kind        = OPK_EOD;
    op.data        = in_byte;
    op.last        = 1'b0;
    if (accept) begin
      if (in_payload_r) begin
        left_nxt = left_r - 16'd1;
        gen      = 1'b1;
        op.kind  = (kind_r == TYPE_RAW) ? OPK_RAW : OPK_RLE;
        op.last  = (left_r == 16'd1);
        if (left_r == 16'd1) begin
          in_payload_nxt = 1'b0;
        end
      end else if (hdr_idx_r == 4'd0) begin
        kind_nxt = in_byte;
        if (in_byte == TYPE_END_DATA) begin
          gen     = 1'b1;
          op.kind = OPK_EOD;
        end else begin
          hdr_idx_nxt = 4'd1;
        end
      end else if (kind_r == TYPE_END_FRAME) begin
        if (hdr_idx_r >= FRAME_HDR_LAST) begin
          hdr_idx_nxt = 4'd0;
          gen         = 1'b1;
          op.kind     = OPK_EOF;
        end else begin
          hdr_idx_nxt = hdr_idx_r + 4'd1;
        end
      end else if (hdr_idx_r < DATA_HDR_LAST) begin
        if (hdr_idx_r == DATA_HDR_LEN_LO) begin
          len_lo_nxt = in_byte;
        end
        hdr_idx_nxt = hdr_idx_r + 4'd1;
      end else begin
        hdr_idx_nxt = 4'd0;
        if (kind_r == TYPE_RLE || kind_r == TYPE_RAW) begin
          if (len != 16'd0) begin
            in_payload_nxt = 1'b1;
            left_nxt       = len;
          end
        end else begin
          gen     = 1'b1;
          op.kind = OPK_ERR;
        end
      end
    end
  end

  assign push = gen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_idx_r    <= 4'd0;
      kind_r       <= 8'd0;
      len_lo_r     <= 8'd0;
      left_r       <= 16'd0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      kind_r       <= kind_nxt;
      len_lo_r     <= len_lo_nxt;
      left_r       <= left_nxt;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> left_r != 16'd0)
    else $error("payload mode with zero bytes left");

  a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_idx_r <= DATA_HDR_LAST && (kind_r != TYPE_END_FRAME || hdr_idx_r <= FRAME_HDR_LAST))
    else $error("header index past header end");

  a_hdr_or_payload: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> hdr_idx_r == 4'd0)
    else $error("header index nonzero during payload");

endmodule

[sv/sbd_queue.sv]
// Short op queue between the front end and the decode back end.
// Depends on sbd_pkg for the op type and depth.
module sbd_queue
  import sbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  sbd_op_t push_op,
  input  logic    pop,
  output sbd_op_t head_op,
  output logic    empty,
  output logic    full
);

  sbd_op_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign empty   = (count_r == QCNT_W'(0));
  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign head_op = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty)
    else $error("queue empty after push");

endmodule

[sv/sbd_back.sv]
// Back end: run-length decode of payload ops and output word register.
// Depends on sbd_pkg; drains sbd_queue.
module sbd_back
  import sbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  sbd_op_t    head_op,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [7:0] out_value,
  output logic [7:0] out_repeat_count
);

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_LIT,
    PH_REPEAT
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] rle_left_r, rle_left_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] ev_r, ev_nxt;
  logic [7:0] val_r, val_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       slot_free;
  logic       emit;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = head_valid && slot_free;

  always_comb begin
    phase_nxt    = phase_r;
    rle_left_nxt = rle_left_r;
    pend_nxt     = pend_r;
    emit         = 1'b0;
    ev_nxt       = EV_DATA;
    val_nxt      = 8'd0;
    cnt_nxt      = 8'd0;
    if (pop) begin
      case (head_op.kind)
        OPK_EOD: begin
          emit   = 1'b1;
          ev_nxt = EV_EOD;
        end
        OPK_EOF: begin
          emit   = 1'b1;
          ev_nxt = EV_EOF;
        end
        OPK_ERR: begin
          emit   = 1'b1;
          ev_nxt = EV_ERR;
        end
        OPK_RAW: begin
          emit    = 1'b1;
          val_nxt = head_op.data;
          cnt_nxt = 8'd1;
        end
        OPK_RLE: begin
          case (phase_r)
            PH_LIT: begin
              emit         = 1'b1;
              val_nxt      = head_op.data;
              cnt_nxt      = 8'd1;
              rle_left_nxt = rle_left_r - 8'd1;
              if (rle_left_r == 8'd1) begin
                phase_nxt = PH_CTRL;
              end
            end
            PH_REPEAT: begin
              emit      = 1'b1;
              val_nxt   = head_op.data;
              cnt_nxt   = pend_r;
              phase_nxt = PH_CTRL;
            end
            default: begin
              if (head_op.data < CTRL_REPEAT_MIN) begin
                rle_left_nxt = head_op.data + 8'd1;
                phase_nxt    = PH_LIT;
              end else begin
                pend_nxt  = (8'hff - head_op.data) + 8'd2;
                phase_nxt = PH_REPEAT;
              end
            end
          endcase
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      if (head_op.last) begin
        phase_nxt    = PH_CTRL;
        rle_left_nxt = 8'd0;
        pend_nxt     = 8'd0;
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CTRL;
      rle_left_r  <= 8'd0;
      pend_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      rle_left_r  <= rle_left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      ev_r  <= ev_nxt;
      val_r <= val_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_value        = val_r;
  assign out_repeat_count = cnt_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_op.last) |=> (phase_r == PH_CTRL && rle_left_r == 8'd0 && pend_r == 8'd0))
    else $error("run state not cleared at block end");

  a_lit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LIT) |-> (rle_left_r != 8'd0 && rle_left_r <= 8'd128))
    else $error("literal count out of range");

  a_no_pop_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !pop)
    else $error("pop while output word held");

endmodule

[verif/sbd_tb_pkg.sv]
// Scoreboard for the scan block deframer: tracks header, payload and run state per byte
// and keeps the queue of event words that the block has to produce.
// Depends on sbd_pkg for type codes, header lengths and event codes.
package sbd_tb_pkg;
  import sbd_pkg::*;

  typedef enum logic [1:0] {
    RUN_CTRL,
    RUN_LITERAL,
    RUN_REPEAT
  } run_phase_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] value;
    logic [7:0] count;
  } stream_event_t;

  class deframe_board;
    logic           in_payload   = 1'b0;
    logic [3:0]     hdr_idx      = '0;
    logic [7:0]     block_kind   = '0;
    logic [7:0]     len_lo       = '0;
    logic [15:0]    payload_left = '0;
    run_phase_t     phase        = RUN_CTRL;
    logic [7:0]     lit_left     = '0;
    logic [7:0]     run_len      = '0;
    int             mismatches   = 0;
    stream_event_t  pending_events[$];

    function void push(event_t ev, logic [7:0] value, logic [7:0] count);
      stream_event_t w;
      w.ev    = ev;
      w.value = value;
      w.count = count;
      pending_events.push_back(w);
    endfunction

    function void clear_run();
      phase    = RUN_CTRL;
      lit_left = '0;
      run_len  = '0;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void take_byte(logic [7:0] b);
      logic [15:0] len;
      if (in_payload) begin
        payload_left = payload_left - 16'd1;
        if (block_kind == TYPE_RAW) begin
          push(EV_DATA, b, 8'd1);
        end else if (phase == RUN_LITERAL) begin
          push(EV_DATA, b, 8'd1);
          lit_left = lit_left - 8'd1;
          if (lit_left == 8'd0) phase = RUN_CTRL;
        end else if (phase == RUN_REPEAT) begin
          push(EV_DATA, b, run_len);
          phase = RUN_CTRL;
        end else if (b < CTRL_REPEAT_MIN) begin
          lit_left = b + 8'd1;
          phase    = RUN_LITERAL;
        end else begin
          run_len = 8'hff - b + 8'd2;
          phase   = RUN_REPEAT;
        end
        if (payload_left == 16'd0) begin
          in_payload = 1'b0;
          clear_run();
        end
      end else if (hdr_idx == 4'd0) begin
        block_kind = b;
        if (b == TYPE_END_DATA) push(EV_EOD, 8'd0, 8'd0);
        else hdr_idx = 4'd1;
      end else if (block_kind == TYPE_END_FRAME) begin
        if (hdr_idx >= FRAME_HDR_LAST) begin
          hdr_idx = 4'd0;
          push(EV_EOF, 8'd0, 8'd0);
        end else begin
          hdr_idx = hdr_idx + 4'd1;
        end
      end else if (hdr_idx < DATA_HDR_LAST) begin
        if (hdr_idx == DATA_HDR_LEN_LO) len_lo = b;
        hdr_idx = hdr_idx + 4'd1;
      end else begin
        hdr_idx = 4'd0;
        len     = {b, len_lo};
        clear_run();
        if (block_kind == TYPE_RLE || block_kind == TYPE_RAW) begin
          if (len != 16'd0) begin
            in_payload   = 1'b1;
            payload_left = len;
          end
        end else begin
          push(EV_ERR, 8'd0, 8'd0);
        end
      end
    endfunction

    function void match_event(logic [1:0] ev, logic [7:0] value, logic [7:0] count);
      stream_event_t w;
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: event %0d value %0d count %0d",
                 $time, ev, value, count);
        return;
      end
      w = pending_events.pop_front();
      if (w !== {ev, value, count}) begin
        mismatches++;
        $display("%0t: expected event %0d value %0d count %0d, got event %0d value %0d count %0d",
                 $time, w.ev, w.value, w.count, ev, value, count);
      end
    endfunction
  endclass

endpackage

[verif/tb_scan_block_deframe_rle_decode.sv]
// Top-level testbench for scan_block_deframe_rle_decode: directed blocks, then random
// well-formed and broken streams under bursty input and stalled output.
// Depends on sbd_pkg, sbd_tb_pkg and the block's RTL.
module tb_scan_block_deframe_rle_decode;
  import sbd_pkg::*;
  import sbd_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1200;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_event_res;
  logic [7:0] out_value;
  logic [7:0] out_repeat_count;

  deframe_board board = new;
  logic [7:0]   payload_q[$];
  int           burst_left = 0;
  int           stream_bytes = 0;
  bit           hold_request = 1'b0;
  int unsigned  cycle_count = 0;

  scan_block_deframe_rle_decode dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_value        (out_value),
    .out_repeat_count (out_repeat_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_event(out_event_res, out_value, out_repeat_count);
  end

  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
        out_stall = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 9) < 7);
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    in_byte = b;
    do @(posedge clk); while (in_stall);
    board.take_byte(b);
    burst_left--;
    stream_bytes++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [7:0] kind, input logic [15:0] len);
    int i;
    send_byte(kind);
    if (kind != TYPE_END_DATA) begin
      for (i = 1; i < FRAME_HDR_LEN; i++) send_byte(8'($urandom_range(0, 255)));
      if (kind != TYPE_END_FRAME) begin
        send_byte(len[7:0]);
        send_byte(len[15:8]);
      end
    end
  endtask

  task automatic send_payload();
    int i;
    for (i = 0; i < payload_q.size(); i++) send_byte(payload_q[i]);
  endtask

  // keep lengths picked up from junk small so the stream resyncs quickly
  task automatic send_junk(input logic [7:0] b);
    if (!board.in_payload && board.hdr_idx == DATA_HDR_LAST) b = 8'd0;
    else if (!board.in_payload && board.hdr_idx == DATA_HDR_LEN_LO) b = b & 8'h1f;
    send_byte(b);
  endtask

  task automatic resync();
    while (board.in_payload || board.hdr_idx != 4'd0) send_junk(8'($urandom_range(0, 255)));
  endtask

  task automatic fill_rle(input int len);
    int c;
    payload_q.delete();
    while (payload_q.size() < len) begin
      if ($urandom_range(0, 1)) begin
        c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
        payload_q.push_back(8'(c));
        repeat (c + 1) payload_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        payload_q.push_back(8'($urandom_range(128, 255)));
        payload_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (payload_q.size() > len) void'(payload_q.pop_back());
  endtask

  task automatic random_block();
    int r;
    int len;
    logic [7:0] kind;
    r = $urandom_range(0, 99);
    len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 40);
    if (r < 45) begin
      send_header(TYPE_RLE, 16'(len));
      fill_rle(len);
      send_payload();
    end else if (r < 60) begin
      payload_q.delete();
      repeat (len) payload_q.push_back(8'($urandom_range(0, 255)));
      send_header(TYPE_RAW, 16'(len));
      send_payload();
    end else if (r < 68) begin
      send_byte(TYPE_END_DATA);
    end else if (r < 76) begin
      send_header(TYPE_END_FRAME, 16'd0);
    end else if (r < 86) begin
      kind = TYPE_JPEG;
      if ($urandom_range(0, 1)) begin
        do kind = 8'($urandom_range(0, 255));
        while (kind == TYPE_END_DATA || kind == TYPE_END_FRAME ||
               kind == TYPE_RLE || kind == TYPE_RAW);
      end
      send_header(kind, 16'($urandom_range(0, 65535)));
      repeat ($urandom_range(0, 4)) send_junk(8'($urandom_range(0, 255)));
      resync();
    end else begin
      repeat ($urandom_range(1, 12)) send_junk(8'($urandom_range(0, 255)));
      resync();
    end
  endtask

  initial begin
    int start_bytes;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_byte(TYPE_END_DATA);
    send_header(TYPE_END_FRAME, 16'd0);
    payload_q = '{8'h01, 8'h00, 8'hff, 8'h80, 8'hab, 8'hff, 8'h00};
    send_header(TYPE_RLE, 16'd7);
    send_payload();
    payload_q = '{8'h00, 8'hff, 8'h5a};
    send_header(TYPE_RAW, 16'd3);
    send_payload();
    send_header(TYPE_JPEG, 16'hffff);
    send_byte(TYPE_END_DATA);
    send_header(8'h00, 16'd1);
    send_header(TYPE_RLE, 16'd0);
    send_byte(TYPE_END_DATA);
    payload_q = '{8'h7f, 8'h11, 8'h22};
    send_header(TYPE_RLE, 16'd3);
    send_payload();
    payload_q = '{8'h85};
    send_header(TYPE_RLE, 16'd1);
    send_payload();
    payload_q = '{8'h00, 8'h33};
    send_header(TYPE_RLE, 16'd2);
    send_payload();

    hold_request = 1'b1;
    start_bytes = stream_bytes;
    while (stream_bytes - start_bytes < RANDOM_BYTES) random_block();

    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
